/* rtl/spmd_pkg.sv */
// Shared types, constants and helper functions for the signal dispatcher.
package spmd_pkg;

   localparam int SIGNAL_COUNT = 32;
   localparam int SIG_LIMIT = (SIGNAL_COUNT < 32) ? SIGNAL_COUNT : 32;
   localparam logic [63:0] LIMIT_ONES = (64'd1 << SIG_LIMIT) - 64'd1;
   localparam logic [31:0] VALID_BITS = LIMIT_ONES[31:0] & 32'hFFFF_FFFE;
   localparam logic [6:0] SIG_LIMIT_W = 7'(SIG_LIMIT);

   // Request codes
   localparam logic [2:0] REQ_POST     = 3'd0;
   localparam logic [2:0] REQ_MASK     = 3'd1;
   localparam logic [2:0] REQ_DELIVER  = 3'd2;
   localparam logic [2:0] REQ_RETURN   = 3'd3;
   localparam logic [2:0] REQ_ALTSTACK = 3'd4;

   // Mask change codes
   localparam logic [1:0] HOW_BLOCK   = 2'd0;
   localparam logic [1:0] HOW_UNBLOCK = 2'd1;
   localparam logic [1:0] HOW_SET     = 2'd2;

   // Dispositions
   localparam logic [1:0] DISP_NONE    = 2'd0;
   localparam logic [1:0] DISP_IGNORE  = 2'd1;
   localparam logic [1:0] DISP_EXIT    = 2'd2;
   localparam logic [1:0] DISP_HANDLER = 2'd3;

   // Handler kinds
   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_IGNORE  = 2'd1;

   // Configuration register indexes
   localparam logic [2:0] CSR_HANDLER_KINDS = 3'd0;
   localparam logic [2:0] CSR_NODEFER       = 3'd1;
   localparam logic [2:0] CSR_ONSTACK       = 3'd2;
   localparam logic [2:0] CSR_DFL_IGNORE    = 3'd3;
   localparam logic [2:0] CSR_DFL_STOP      = 3'd4;
   localparam logic [2:0] CSR_KILL_NUM      = 3'd5;
   localparam logic [2:0] CSR_STOP_NUM      = 3'd6;
   localparam logic [2:0] CSR_CONT_NUM      = 3'd7;

   localparam logic [31:0] DFL_IGNORE_RESET = 32'd1350696960;
   localparam logic [31:0] DFL_STOP_RESET   = 32'd7340032;
   localparam logic [4:0]  KILL_RESET       = 5'd9;
   localparam logic [4:0]  STOP_RESET       = 5'd19;
   localparam logic [4:0]  CONT_RESET       = 5'd18;

   typedef struct packed {
      logic [63:0] handler_kinds;
      logic [31:0] nodefer_set;
      logic [31:0] onstack_request_set;
      logic [31:0] default_ignore_set;
      logic [31:0] default_stop_set;
      logic [4:0]  kill_number;
      logic [4:0]  stop_number;
      logic [4:0]  cont_number;
   } spmd_cfg_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [5:0]  signal_number;
      logic [1:0]  mask_how;
      logic [31:0] mask_value;
      logic        altstack_disable;
      logic        altstack_on;
   } spmd_req_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  delivered_signal;
      logic [1:0]  disposition;
      logic [4:0]  exit_signal;
      logic        alt_stack_run;
      logic [31:0] saved_mask;
      logic [1:0]  old_altstack_flags;
      logic [31:0] visible_pending;
      logic        delivery_due;
   } spmd_rsp_type;

   function automatic logic [31:0] bit_of(input logic [4:0] n);
      bit_of = 32'd1 << n;
   endfunction

   // Lowest set bit, 0 when empty
   function automatic logic [4:0] lowest_bit(input logic [31:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) r = 5'(i);
      end
      lowest_bit = r;
   endfunction

endpackage

/* rtl/spmd_channels.sv */
// Handshake interfaces for the request, response and register write channels.
interface spmd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [5:0]  signal_number;
   logic [1:0]  mask_how;
   logic [31:0] mask_value;
   logic        altstack_disable;
   logic        altstack_on;
   modport source (output valid, req_type, signal_number, mask_how, mask_value,
                   altstack_disable, altstack_on, input ready);
   modport sink (input valid, req_type, signal_number, mask_how, mask_value,
                 altstack_disable, altstack_on, output ready);
endinterface

interface spmd_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [4:0]  delivered_signal;
   logic [1:0]  disposition;
   logic [4:0]  exit_signal;
   logic        alt_stack_run;
   logic [31:0] saved_mask;
   logic [1:0]  old_altstack_flags;
   logic [31:0] visible_pending;
   logic        delivery_due;
   modport source (output valid, status, delivered_signal, disposition, exit_signal,
                   alt_stack_run, saved_mask, old_altstack_flags, visible_pending,
                   delivery_due, input ready);
   modport sink (input valid, status, delivered_signal, disposition, exit_signal,
                 alt_stack_run, saved_mask, old_altstack_flags, visible_pending,
                 delivery_due, output ready);
endinterface

interface spmd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/spmd_csr.sv */
// Configuration registers of the signal dispatcher.
module spmd_csr
   import spmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  logic [2:0]   wr_index,
   input  logic [63:0]  wr_data,
   output spmd_cfg_type cfg
);

   spmd_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_HANDLER_KINDS: cfg_in.handler_kinds = wr_data;
            CSR_NODEFER:       cfg_in.nodefer_set = wr_data[31:0];
            CSR_ONSTACK:       cfg_in.onstack_request_set = wr_data[31:0];
            CSR_DFL_IGNORE:    cfg_in.default_ignore_set = wr_data[31:0];
            CSR_DFL_STOP:      cfg_in.default_stop_set = wr_data[31:0];
            CSR_KILL_NUM:      cfg_in.kill_number = wr_data[4:0];
            CSR_STOP_NUM:      cfg_in.stop_number = wr_data[4:0];
            CSR_CONT_NUM:      cfg_in.cont_number = wr_data[4:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.handler_kinds <= '0;
         cfg_ff.nodefer_set <= '0;
         cfg_ff.onstack_request_set <= '0;
         cfg_ff.default_ignore_set <= DFL_IGNORE_RESET;
         cfg_ff.default_stop_set <= DFL_STOP_RESET;
         cfg_ff.kill_number <= KILL_RESET;
         cfg_ff.stop_number <= STOP_RESET;
         cfg_ff.cont_number <= CONT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/spmd_core.sv */
// Request register, signal state and the single-pass dispatch logic.
module spmd_core
   import spmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  spmd_cfg_type cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  spmd_req_type req_data,
   output logic         push,
   input  logic         room,
   output spmd_rsp_type push_data
);

   logic         in_valid_ff, in_valid_in;
   spmd_req_type in_ff;
   logic [31:0]  pending_ff, pending_in;
   logic [31:0]  blocked_ff, blocked_in;
   logic         in_use_ff, in_use_in;
   logic         disabled_ff, disabled_in;

   logic         move;
   logic [31:0]  unblk, ready_set, ignored, b;
   logic [4:0]   sig;
   logic [1:0]   kind;
   spmd_rsp_type rsp;

   assign move = in_valid_ff & room;
   assign req_ready = ~in_valid_ff | move;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~move);

   assign unblk = bit_of(cfg.kill_number) | bit_of(cfg.stop_number);
   assign ready_set = pending_ff & VALID_BITS & (~blocked_ff | unblk);

   always_comb begin
      for (int s = 0; s < 32; s++) begin
         ignored[s] = (cfg.handler_kinds[2*s +: 2] == KIND_IGNORE);
      end
   end

   always_comb begin
      if (ready_set[cfg.kill_number]) sig = cfg.kill_number;
      else if (ready_set[cfg.stop_number]) sig = cfg.stop_number;
      else sig = lowest_bit(ready_set);
   end

   assign b = bit_of(sig);
   assign kind = cfg.handler_kinds[{sig, 1'b0} +: 2];

   always_comb begin
      pending_in = pending_ff;
      blocked_in = blocked_ff;
      in_use_in = in_use_ff;
      disabled_in = disabled_ff;
      rsp = '0;
      rsp.saved_mask = blocked_ff;
      rsp.old_altstack_flags = {disabled_ff, in_use_ff};
      case (in_ff.req_type)
         REQ_POST: begin
            if (in_ff.signal_number != 6'd0 && {1'b0, in_ff.signal_number} < SIG_LIMIT_W)
               pending_in = pending_ff | (bit_of(in_ff.signal_number[4:0]) & VALID_BITS);
            else
               rsp.status = 1'b1;
         end
         REQ_MASK: begin
            case (in_ff.mask_how)
               HOW_BLOCK:   blocked_in = blocked_ff | in_ff.mask_value;
               HOW_UNBLOCK: blocked_in = blocked_ff & ~in_ff.mask_value;
               HOW_SET:     blocked_in = in_ff.mask_value;
               default:     rsp.status = 1'b1;
            endcase
         end
         REQ_DELIVER: begin
            if (ready_set != 32'd0) begin
               rsp.delivered_signal = sig;
               pending_in = pending_ff & ~b;
               if (sig == cfg.kill_number) begin
                  rsp.disposition = DISP_EXIT;
                  rsp.exit_signal = cfg.kill_number;
               end else if (sig == cfg.stop_number) begin
                  rsp.disposition = DISP_EXIT;
                  rsp.exit_signal = cfg.stop_number;
               end else if (kind == KIND_IGNORE ||
                            (kind == KIND_DEFAULT && (cfg.default_ignore_set & b) != 32'd0)) begin
                  rsp.disposition = DISP_IGNORE;
               end else if (kind == KIND_DEFAULT && (cfg.default_stop_set & b) != 32'd0) begin
                  rsp.disposition = DISP_EXIT;
                  rsp.exit_signal = cfg.stop_number;
               end else if (sig == cfg.cont_number) begin
                  rsp.disposition = DISP_EXIT;
                  rsp.exit_signal = cfg.cont_number;
               end else if (kind == KIND_DEFAULT) begin
                  rsp.disposition = DISP_EXIT;
                  rsp.exit_signal = cfg.kill_number;
               end else begin
                  rsp.disposition = DISP_HANDLER;
                  if ((cfg.onstack_request_set & b) != 32'd0 && !in_use_ff && !disabled_ff) begin
                     rsp.alt_stack_run = 1'b1;
                     in_use_in = 1'b1;
                  end
                  // mask own signal while its handler runs
                  if ((cfg.nodefer_set & b) == 32'd0)
                     blocked_in = blocked_ff | b;
               end
            end
         end
         REQ_RETURN: begin
            in_use_in = 1'b0;
            blocked_in = in_ff.mask_value;
         end
         REQ_ALTSTACK: begin
            in_use_in = in_ff.altstack_on;
            disabled_in = in_ff.altstack_disable;
         end
         default: rsp.status = 1'b1;
      endcase
      rsp.visible_pending = pending_in & ~(blocked_in & ignored);
      rsp.delivery_due = (pending_in & (~blocked_in | unblk)) != 32'd0;
   end

   assign push = move;
   assign push_data = rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff <= '0;
         blocked_ff <= '0;
         in_use_ff <= 1'b0;
         disabled_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) begin
            pending_ff <= pending_in;
            blocked_ff <= blocked_in;
            in_use_ff <= in_use_in;
            disabled_ff <= disabled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

endmodule

/* rtl/spmd_out_fifo.sv */
// Two-entry response buffer between the dispatch logic and the response channel.
module spmd_out_fifo
   import spmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  spmd_rsp_type push_data,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output spmd_rsp_type out_data
);

   spmd_rsp_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign pop = out_valid & out_ready;
   // full buffer still takes a request when the head leaves this cycle
   assign room = (count_ff != 2'd2) | out_ready;
   assign out_data = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/signal_pending_mask_dispatcher.sv */
// Signal pending/mask dispatcher: top level.
//
// Channels: req_ch takes one command per request (post, mask change, deliver,
// handler return, set alternate stack); rsp_ch returns exactly one response per
// request, in order; csr_ch writes the configuration registers by index and is
// always ready. Write configuration only while no request is in flight.
// Datapath: a request accepted on req_ch is registered, processed by one pass
// of combinational logic against the signal state, and its response is
// written into the response buffer, which drives rsp_ch.
// Throughput: one request per cycle while the response buffer has room,
// set by the single-pass dispatch logic.
// The two-entry response buffer keeps requests flowing while the receiver
// takes a waiting response; when the receiver stalls, at most three requests
// (one registered, two buffered) are held and req_ch.ready then drops until
// the receiver takes a response.
// Reset (synchronous, active high) empties the pipeline, clears pending set,
// mask and alternate-stack flags, and loads configuration reset values.
module signal_pending_mask_dispatcher
   import spmd_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   spmd_req_if.sink   req_ch,
   spmd_rsp_if.source rsp_ch,
   spmd_csr_if.sink   csr_ch
);

   spmd_cfg_type cfg;
   spmd_req_type req_data;
   spmd_rsp_type push_data, out_data;
   logic         push, room;

   assign csr_ch.ready = 1'b1;

   spmd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   assign req_data.req_type = req_ch.req_type;
   assign req_data.signal_number = req_ch.signal_number;
   assign req_data.mask_how = req_ch.mask_how;
   assign req_data.mask_value = req_ch.mask_value;
   assign req_data.altstack_disable = req_ch.altstack_disable;
   assign req_data.altstack_on = req_ch.altstack_on;

   spmd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_data),
      .push      (push),
      .room      (room),
      .push_data (push_data)
   );

   spmd_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.status = out_data.status;
   assign rsp_ch.delivered_signal = out_data.delivered_signal;
   assign rsp_ch.disposition = out_data.disposition;
   assign rsp_ch.exit_signal = out_data.exit_signal;
   assign rsp_ch.alt_stack_run = out_data.alt_stack_run;
   assign rsp_ch.saved_mask = out_data.saved_mask;
   assign rsp_ch.old_altstack_flags = out_data.old_altstack_flags;
   assign rsp_ch.visible_pending = out_data.visible_pending;
   assign rsp_ch.delivery_due = out_data.delivery_due;

endmodule
